// File: sv/bsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, constants and the window crop function for the BMP stream
// to RGB565 converter.
// ----------------------------------------------------------------------------
package bsr_pkg;

	localparam int HEADER_BYTES = 54;
	localparam logic [5:0] HEADER_LAST = 6'(HEADER_BYTES);

	// configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

	typedef struct packed {
		logic [7:0] origin_x;
		logic [7:0] origin_y;
		logic [7:0] image_width;
		logic [7:0] image_height;
		logic [7:0] screen_width;
		logic [7:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic [7:0] w;
		logic [7:0] h;
		logic [9:0] w3;
		logic [9:0] row_size;
	} win_t;

	typedef struct packed {
		logic [15:0] rgb565;
		logic [7:0]  pixel_column;
		logic [7:0]  pixel_row;
		logic        end_of_row;
		logic        end_of_image;
	} pix_t;

	function automatic logic [7:0] crop(input logic [7:0] origin, input logic [7:0] size,
			input logic [7:0] screen);
		logic [8:0] last;
		last = {1'b0, origin} + {1'b0, size} - 9'd1;
		if (origin >= screen || size == 8'd0) begin
			return 8'd0;
		end else if (last >= {1'b0, screen}) begin
			return screen - origin;
		end else begin
			return size;
		end
	endfunction

endpackage

// File: sv/bsr_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_window
// Crops the image to the screen and derives the padded row size.
// ----------------------------------------------------------------------------
module bsr_window (
	input  bsr_pkg::cfg_t cfg,
	output bsr_pkg::win_t win
);
	import bsr_pkg::*;

	logic [9:0] raw3;

	assign raw3 = {2'b00, cfg.image_width} * 10'd3;

	always_comb begin
		win.w        = crop(cfg.origin_x, cfg.image_width, cfg.screen_width);
		win.h        = crop(cfg.origin_y, cfg.image_height, cfg.screen_height);
		win.w3       = {2'b00, win.w} * 10'd3;
		// round up to a multiple of four bytes
		win.row_size = (raw3 + 10'd3) & ~10'd3;
	end

endmodule

// File: sv/bsr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_core
// Header skip, row position counters and pixel assembly for one byte a cycle while step is high.
// ----------------------------------------------------------------------------
module bsr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    file_byte,
	input  logic          start_of_file,
	input  bsr_pkg::win_t win,
	output logic          hit,
	output bsr_pkg::pix_t pix
);
	import bsr_pkg::*;

	logic [5:0] header_count_q, hc, hc_n;
	logic [9:0] byte_in_row_q, bir, bir_n;
	logic [1:0] phase_q, ph, ph_n;
	logic [7:0] col_q, col, col_n;
	logic [7:0] row_count_q, rc, rc_n;
	logic       image_done_q, done, done_n;
	logic [7:0] held_blue_q, held_green_q;
	logic       take_blue, take_green, last_col, last_row;
	logic [9:0] pos1;

	always_comb begin
		// start mark clears the counters before the byte is handled
		hc   = start_of_file ? 6'd0 : header_count_q;
		bir  = start_of_file ? 10'd0 : byte_in_row_q;
		ph   = start_of_file ? 2'd0 : phase_q;
		col  = start_of_file ? 8'd0 : col_q;
		rc   = start_of_file ? 8'd0 : row_count_q;
		done = start_of_file ? 1'b0 : image_done_q;

		hc_n = hc; bir_n = bir; ph_n = ph; col_n = col; rc_n = rc; done_n = done;
		hit = 1'b0; take_blue = 1'b0; take_green = 1'b0;
		last_col = (col == win.w - 8'd1);
		last_row = (rc == win.h - 8'd1);
		pos1 = bir + 10'd1;

		if (done || win.w == 8'd0 || win.h == 8'd0) begin
			// drop
		end else if (hc < HEADER_LAST) begin
			hc_n = hc + 6'd1;
		end else if (rc >= win.h) begin
			// drop
		end else begin
			if (bir < win.w3) begin
				case (ph)
					2'd0:    take_blue = 1'b1;
					2'd1:    take_green = 1'b1;
					default: begin
						hit = 1'b1;
						if (last_col && last_row) done_n = 1'b1;
					end
				endcase
			end
			if (pos1 >= win.row_size) begin
				bir_n = 10'd0;
				ph_n  = 2'd0;
				col_n = 8'd0;
				rc_n  = rc + 8'd1;
				if (rc_n >= win.h) done_n = 1'b1;
			end else begin
				bir_n = pos1;
				if (ph == 2'd2) begin
					ph_n  = 2'd0;
					col_n = col + 8'd1;
				end else begin
					ph_n = ph + 2'd1;
				end
			end
		end

		pix.rgb565       = {file_byte[7:3], held_green_q[7:2], held_blue_q[7:3]};
		pix.pixel_column = col;
		pix.pixel_row    = rc;
		pix.end_of_row   = last_col;
		pix.end_of_image = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			byte_in_row_q  <= '0;
			phase_q        <= '0;
			col_q          <= '0;
			row_count_q    <= '0;
			image_done_q   <= 1'b0;
		end else if (step) begin
			header_count_q <= hc_n;
			byte_in_row_q  <= bir_n;
			phase_q        <= ph_n;
			col_q          <= col_n;
			row_count_q    <= rc_n;
			image_done_q   <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_blue_q  <= '0;
			held_green_q <= '0;
		end else if (step) begin
			if (take_blue) held_blue_q <= file_byte;
			if (take_green) held_green_q <= file_byte;
		end
	end

endmodule

// File: sv/bmp_stream_to_rgb565.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565
// Turns a 24-bit BMP byte stream into cropped RGB565 pixels.
// ----------------------------------------------------------------------------
// A pixel passes the input register and then the result register.
// Throughput: one byte per cycle while no pixel stalls at the output; the counter
// update in bsr_core sets the pace. A pixel waiting at the output holds the byte
// stage; a byte is then taken only while that stage is empty.
// Reset clears counters, held bytes, valid flags and sets the registers to
// 0/0/128/160/128/160.
module bmp_stream_to_rgb565 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  file_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] rgb565,
	output logic [7:0]  pixel_column,
	output logic [7:0]  pixel_row,
	output logic        end_of_row,
	output logic        end_of_image,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import bsr_pkg::*;

	cfg_t       cfg_q;
	win_t       win;
	pix_t       pix, pix_q;
	logic       valid_s1, sof_s1, advance, step, hit, out_valid_q;
	logic [7:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= 8'd0;
			cfg_q.origin_y      <= 8'd0;
			cfg_q.image_width   <= 8'd128;
			cfg_q.image_height  <= 8'd160;
			cfg_q.screen_width  <= 8'd128;
			cfg_q.screen_height <= 8'd160;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data;
				REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data;
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data;
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data;
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				default: ;
			endcase
		end
	end

	bsr_window u_window (
		.cfg (cfg_q),
		.win (win)
	);

	// advance the byte stage unless a pixel is stuck at the output
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= file_byte;
			sof_s1  <= start_of_file;
		end
	end

	bsr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.file_byte     (byte_s1),
		.start_of_file (sof_s1),
		.win           (win),
		.hit           (hit),
		.pix           (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) pix_q <= pix;
	end

	assign out_valid    = out_valid_q;
	assign rgb565       = pix_q.rgb565;
	assign pixel_column = pix_q.pixel_column;
	assign pixel_row    = pix_q.pixel_row;
	assign end_of_row   = pix_q.end_of_row;
	assign end_of_image = pix_q.end_of_image;

	a_eoi_on_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_image |-> end_of_row)
		else $error("end_of_image without end_of_row");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("byte stage lost a stalled byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rgb565))
		else $error("pending pixel overwritten");

endmodule

// File: dv/bmp_stream_to_rgb565_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_tb
// Streams BMP files of many window settings through the converter and checks
// every pixel request against an in-bench prediction of the crop and packing.
// Both handshakes idle in random bursts, and settings change only while idle.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb565_tb;
	import bsr_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEM_TARGET  = 1900;

	typedef struct packed {
		logic [7:0] data;
		logic       mark;
	} file_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  file_byte = '0;
	logic        start_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] rgb565;
	logic [7:0]  pixel_column;
	logic [7:0]  pixel_row;
	logic        end_of_row;
	logic        end_of_image;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_ORIGIN_X;
	logic [7:0]  cfg_data = '0;

	file_req_t byte_pending[$];
	pix_t      pix_expected[$];
	file_req_t next_req;
	int        in_gap = 0;
	int        out_gap = 0;
	int        err_count = 0;
	int        cycle_count = 0;
	int        stim_count = 0;
	bit        idle_en = 1'b1;

	// window settings and converter state as the bench sees them
	cfg_t       cfg_shadow = '{8'd0, 8'd0, 8'd128, 8'd160, 8'd128, 8'd160};
	logic [5:0] hdr_seen = '0;
	logic [9:0] row_pos = '0;
	logic [7:0] rows_done = '0;
	logic [7:0] blue_hold = '0;
	logic [7:0] green_hold = '0;
	logic       frame_done = 1'b0;

	bmp_stream_to_rgb565 uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.file_byte(file_byte),
		.start_of_file(start_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rgb565(rgb565),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.end_of_row(end_of_row),
		.end_of_image(end_of_image),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #10 clk = ~clk;

	function automatic int window_extent(input int origin, input int size, input int screen);
		if (origin >= screen || size == 0) begin
			return 0;
		end
		return (origin + size > screen) ? screen - origin : size;
	endfunction

	function automatic int padded_row(input int width);
		return (width * 3 + 3) & ~3;
	endfunction

	function automatic void predict_pixel(input logic [7:0] b, input logic mark);
		int   w;
		int   h;
		int   row_bytes;
		int   pos;
		pix_t px;
		if (mark) begin
			hdr_seen = '0;
			row_pos = '0;
			rows_done = '0;
			frame_done = 1'b0;
		end
		w = window_extent(int'(cfg_shadow.origin_x), int'(cfg_shadow.image_width),
			int'(cfg_shadow.screen_width));
		h = window_extent(int'(cfg_shadow.origin_y), int'(cfg_shadow.image_height),
			int'(cfg_shadow.screen_height));
		row_bytes = padded_row(int'(cfg_shadow.image_width));
		if (frame_done || w == 0 || h == 0) begin
			return;
		end
		if (hdr_seen < HEADER_BYTES) begin
			hdr_seen++;
			return;
		end
		if (rows_done >= h) begin
			return;
		end
		pos = int'(row_pos);
		if (pos < w * 3) begin
			case (pos % 3)
				0: begin
					blue_hold = b;
				end
				1: begin
					green_hold = b;
				end
				default: begin
					px.rgb565 = {b[7:3], green_hold[7:2], blue_hold[7:3]};
					px.pixel_column = 8'(pos / 3);
					px.pixel_row = rows_done;
					px.end_of_row = (pos / 3 == w - 1);
					px.end_of_image = px.end_of_row && (rows_done == h - 1);
					pix_expected.push_back(px);
					if (px.end_of_image) begin
						frame_done = 1'b1;
					end
				end
			endcase
		end
		pos++;
		// a position at or past the row size closes the row, even after a shrink
		if (pos >= row_bytes) begin
			row_pos = '0;
			rows_done++;
			if (rows_done >= h) begin
				frame_done = 1'b1;
			end
		end else begin
			row_pos = 10'(pos);
		end
	endfunction

	function automatic void flag_field(input string field, input logic [15:0] want,
			input logic [15:0] seen);
		err_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
	endfunction

	function automatic void check_pixel(input pix_t seen);
		pix_t want;
		if (pix_expected.size() == 0) begin
			err_count++;
			$display("%0t: unexpected pixel, expected none, actual %0h col %0d row %0d",
				$time, seen.rgb565, seen.pixel_column, seen.pixel_row);
			return;
		end
		want = pix_expected.pop_front();
		if (want.rgb565 !== seen.rgb565)
			flag_field("rgb565", want.rgb565, seen.rgb565);
		if (want.pixel_column !== seen.pixel_column)
			flag_field("pixel_column", 16'(want.pixel_column), 16'(seen.pixel_column));
		if (want.pixel_row !== seen.pixel_row)
			flag_field("pixel_row", 16'(want.pixel_row), 16'(seen.pixel_row));
		if (want.end_of_row !== seen.end_of_row)
			flag_field("end_of_row", 16'(want.end_of_row), 16'(seen.end_of_row));
		if (want.end_of_image !== seen.end_of_image)
			flag_field("end_of_image", 16'(want.end_of_image), 16'(seen.end_of_image));
	endfunction

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			file_byte <= '0;
			start_of_file <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_pixel(file_byte, start_of_file);
			end
			// hold the payload until the request is taken
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (byte_pending.size() != 0 && idle_en && $urandom_range(0, 11) == 0) begin
					in_gap = $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else if (byte_pending.size() != 0) begin
					next_req = byte_pending.pop_front();
					in_valid <= 1'b1;
					file_byte <= next_req.data;
					start_of_file <= next_req.mark;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_pixel({rgb565, pixel_column, pixel_row, end_of_row, end_of_image});
			end
			if (out_gap != 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic set_window(input int ox, input int oy, input int iw, input int ih,
			input int sw, input int sh);
		cfg_t c;
		c = '{8'(ox), 8'(oy), 8'(iw), 8'(ih), 8'(sw), 8'(sh)};
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_data <= c.origin_x;
		@(posedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_data <= c.origin_y;
		@(posedge clk);
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= c.image_width;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= c.image_height;
		@(posedge clk);
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= c.screen_width;
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= c.screen_height;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_shadow = c;
	endtask

	// first byte carries the mark; noisy streams restart now and then
	task automatic queue_bytes(input bit mark, input int count, input bit noisy);
		file_req_t r;
		for (int i = 0; i < count; i++) begin
			r.data = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 15) == 0) begin
				r.data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			r.mark = (i == 0) ? mark : (noisy && $urandom_range(0, 63) == 0);
			byte_pending.push_back(r);
		end
		stim_count += count;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (byte_pending.size() != 0 || in_valid || pix_expected.size() != 0);
		// let bytes that make no pixel clear the pipeline
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int pick_origin();
		case ($urandom_range(0, 15))
			0: return 255;
			1: return $urandom_range(0, 255);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic int pick_screen();
		case ($urandom_range(0, 19))
			0: return 255;
			1: return 0;
			2: return $urandom_range(1, 255);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int pick_size(input int top);
		return ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, top);
	endfunction

	initial begin
		int full;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stream with no start mark right after reset
		set_window(0, 0, 2, 2, 8, 8);
		queue_bytes(1'b0, HEADER_BYTES + 16 + 3, 1'b0);
		wait_drained();

		// widest image, one row
		set_window(0, 0, 255, 1, 255, 255);
		queue_bytes(1'b1, HEADER_BYTES + padded_row(255) + 4, 1'b0);
		wait_drained();

		// crop at the far corner of the largest screen
		set_window(252, 254, 8, 2, 255, 255);
		queue_bytes(1'b1, HEADER_BYTES + padded_row(8) + 6, 1'b0);
		wait_drained();

		// window ends exactly on the screen edge, then one past it
		set_window(5, 6, 3, 2, 8, 8);
		queue_bytes(1'b1, HEADER_BYTES + padded_row(3) * 2 + 2, 1'b0);
		wait_drained();
		set_window(6, 7, 3, 2, 8, 8);
		queue_bytes(1'b1, HEADER_BYTES + padded_row(3) * 2 + 2, 1'b0);
		wait_drained();

		// origin off screen in either direction
		set_window(200, 0, 2, 2, 100, 8);
		queue_bytes(1'b1, HEADER_BYTES + 16, 1'b0);
		wait_drained();
		set_window(0, 9, 2, 2, 8, 9);
		queue_bytes(1'b1, HEADER_BYTES + 16, 1'b0);
		wait_drained();

		// zero image size
		set_window(0, 0, 0, 2, 8, 8);
		queue_bytes(1'b1, HEADER_BYTES + 16, 1'b0);
		wait_drained();
		set_window(0, 0, 2, 0, 8, 8);
		queue_bytes(1'b1, HEADER_BYTES + 16, 1'b0);
		wait_drained();

		// shrink the row while inside it
		set_window(0, 0, 3, 2, 8, 8);
		queue_bytes(1'b1, HEADER_BYTES + 7, 1'b0);
		wait_drained();
		set_window(0, 0, 1, 2, 8, 8);
		queue_bytes(1'b0, 12, 1'b0);
		wait_drained();

		// restart in the middle of pixel data, then trailing bytes
		set_window(1, 1, 2, 3, 8, 8);
		queue_bytes(1'b1, HEADER_BYTES + 10, 1'b0);
		queue_bytes(1'b1, HEADER_BYTES + padded_row(2) * 3 + 5, 1'b0);
		wait_drained();

		while (stim_count < ITEM_TARGET) begin
			idle_en = (stim_count < ITEM_TARGET - 150) && ($urandom_range(0, 3) != 0);
			set_window(pick_origin(), pick_origin(), pick_size(6), pick_size(4),
				pick_screen(), pick_screen());
			repeat ($urandom_range(1, 3)) begin
				full = HEADER_BYTES + padded_row(int'(cfg_shadow.image_width)) *
					int'(cfg_shadow.image_height);
				case ($urandom_range(0, 9))
					0: queue_bytes(1'b1, $urandom_range(1, full), 1'b1);
					1: queue_bytes(1'($urandom_range(0, 1)), $urandom_range(1, 30), 1'b1);
					default: queue_bytes(1'b1, full + $urandom_range(0, 6),
						1'($urandom_range(0, 1)));
				endcase
			end
			wait_drained();
		end

		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
